// ===== rtl/wbc_pkg.sv =====
// wbc_pkg: shared types and constants of the witness ball classifier.
// Used by witness_ball_classifier_top, wbc_front and wbc_back; depends on nothing.
`default_nettype none

package wbc_pkg;

    localparam int CFG_W      = 32;  // widest configuration register
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_REPORT = 8;   // count results are limited to eight classes
    localparam int CNT_W      = 7;
    localparam int RUN_LEN_W  = 4;   // holds 0..MAX_REPORT
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RATIO      = 2'd0,
        CFG_REPORT_DOUBLES = 2'd1,
        CFG_CLASSES_IN_USE = 2'd2
    } cfg_reg_t;

    // input word functions
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_DIST = 1'b1
    } func_t;

    typedef struct packed {
        logic        func;
        logic [5:0]  witness_index;
        logic [31:0] radius;
        logic [2:0]  witness_class;
        logic [31:0] distance;
        logic        end_of_observation;
    } in_word_t;

    typedef struct packed {
        logic        call_made;
        logic [2:0]  call_class;
        logic [2:0]  count_class;
        logic [6:0]  overlap_count;
        logic        is_count;
        logic        last_of_run;
    } out_word_t;

    // one finished observation, handed from the front to the back
    typedef struct packed {
        logic                               made;
        logic [2:0]                         call_class;
        logic                               have_best;
        logic [2:0]                         best_class;
        logic [RUN_LEN_W-1:0]               run_len;
        logic [MAX_REPORT-1:0][CNT_W-1:0]   counts;
    } run_t;

endpackage

`default_nettype wire

// ===== rtl/witness_ball_classifier_top.sv =====
// witness_ball_classifier_top: input word every cycle; the first result word follows the closing
// distance, then one word per cycle while m_ready is high (1 + classes, up to 9).
// Output rate is set by the back half's single result register; the front takes
// a word each cycle and stalls only while a finished observation waits at the
// queue with all QUEUE_DEPTH places taken.
// Synchronous active-low reset clears control and search state and loads the
// register defaults; the witness table is not cleared and needs loading first.
`default_nettype none

module witness_ball_classifier_top #(
    parameter int MAX_WITNESSES = 64,
    parameter int NUM_CLASSES   = 8,
    parameter int DIST_WIDTH    = 32,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic [wbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [wbc_pkg::CFG_W-1:0]     cfg_wdata,
    // input words
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire wbc_pkg::in_word_t             s_data,
    // result words
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output wbc_pkg::out_word_t                 m_data
);

    // classes actually reported: never beyond the table's classes nor eight
    localparam int NCC = (NUM_CLASSES < wbc_pkg::MAX_REPORT) ? NUM_CLASSES
                                                             : wbc_pkg::MAX_REPORT;
    localparam int QW  = $bits(wbc_pkg::run_t);

    // configuration registers
    logic [31:0] max_ratio_reg;
    logic        report_reg;
    logic [3:0]  classes_reg;
    logic [wbc_pkg::RUN_LEN_W-1:0] run_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_ratio_reg <= 32'h0001_0000;   // 1.0 in Q16.16
            report_reg    <= 1'b1;
            classes_reg   <= 4'd8;
        end else if (cfg_we) begin
            case (wbc_pkg::cfg_reg_t'(cfg_index))
                wbc_pkg::CFG_MAX_RATIO:      max_ratio_reg <= cfg_wdata[31:0];
                wbc_pkg::CFG_REPORT_DOUBLES: report_reg    <= cfg_wdata[0];
                wbc_pkg::CFG_CLASSES_IN_USE: classes_reg   <= cfg_wdata[3:0];
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // count words per observation; zero when reporting is off
    always_comb begin
        run_len = (classes_reg > 4'(NCC)) ? 4'(NCC) : classes_reg;
        if (!report_reg) begin
            run_len = '0;
        end
    end

    // front half <-> queue
    logic              f_push, f_ready;
    wbc_pkg::run_t     f_run, b_run;
    logic [QW-1:0]     b_bits;
    logic              b_valid, b_pop;

    wbc_front #(
        .MAX_WITNESSES (MAX_WITNESSES),
        .NUM_CLASSES   (NUM_CLASSES),
        .DIST_WIDTH    (DIST_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_data    (s_data),
        .s_ready   (s_ready),
        .max_ratio (max_ratio_reg),
        .run_len   (run_len),
        .q_ready   (f_ready),
        .q_push    (f_push),
        .q_data    (f_run)
    );

    // finished observations wait here so the front keeps streaming
    wbc_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_data  (f_run),
        .push_ready (f_ready),
        .pop        (b_pop),
        .pop_valid  (b_valid),
        .pop_data   (b_bits)
    );

    assign b_run = wbc_pkg::run_t'(b_bits);

    // back half: call word, then count words
    wbc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (b_valid),
        .q_data  (b_run),
        .q_pop   (b_pop),
        .m_valid (m_valid),
        .m_data  (m_data),
        .m_ready (m_ready)
    );

endmodule

`default_nettype wire

// ===== rtl/wbc_ram.sv =====
// wbc_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module wbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wbc_fifo.sv =====
// wbc_fifo: small register FIFO between the front and back halves.
// No dependencies.
`default_nettype none

module wbc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic             do_push, do_pop;

    assign push_ready = (fill_reg != CW'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = store_reg[rptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wbc_front.sv =====
// wbc_front: accepts words, keeps the witness table, runs the best-ratio search
// and overlap counts, and hands one run_t per observation to the queue.
// Depends on wbc_pkg and wbc_ram.
`default_nettype none

module wbc_front #(
    parameter int MAX_WITNESSES = 64,
    parameter int NUM_CLASSES   = 8,
    parameter int DIST_WIDTH    = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire wbc_pkg::in_word_t             s_data,
    output logic                               s_ready,
    input  wire logic [31:0]                   max_ratio,
    input  wire logic [wbc_pkg::RUN_LEN_W-1:0] run_len,
    input  wire logic                          q_ready,
    output logic                               q_push,
    output wbc_pkg::run_t                      q_data
);

    localparam int DW = DIST_WIDTH;
    localparam int PW = 2 * DW;
    localparam int MW = 32 + DW;
    localparam int AW = (MAX_WITNESSES > 1) ? $clog2(MAX_WITNESSES) : 1;
    localparam int RW = 3 + DW;
    localparam int NR = wbc_pkg::MAX_REPORT;
    localparam int CW = wbc_pkg::CNT_W;

    // global advance: only a full queue in front of stage 4 stalls the pipe
    logic adv;
    logic acc;
    logic is_dist;
    logic s4_valid_reg;
    logic [12:0]   idx_ext;
    logic          idx_ok0;
    logic [AW-1:0] addr;
    logic [DW-1:0] rad_in, rad_wr;
    logic [RW-1:0] rdata;

    assign adv     = !(s4_valid_reg && !q_ready);
    assign s_ready = adv;
    assign acc     = s_valid && adv;
    assign is_dist = (s_data.func == wbc_pkg::FUNC_DIST);
    assign idx_ext = 13'(s_data.witness_index);
    assign idx_ok0 = (idx_ext < 13'(MAX_WITNESSES));
    assign addr    = idx_ext[AW-1:0];
    assign rad_in  = s_data.radius[DW-1:0];
    assign rad_wr  = (rad_in == '0) ? DW'(1) : rad_in;

    wbc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WITNESSES)
    ) u_table (
        .aclk  (aclk),
        .we    (acc && !is_dist && idx_ok0),
        .waddr (addr),
        .wdata ({s_data.witness_class, rad_wr}),
        .re    (acc && is_dist),
        .raddr (addr),
        .rdata (rdata)
    );

    // stage 1: table read in flight
    logic          s1_valid_reg;
    logic          s1_ok_reg, s1_end_reg;
    logic [DW-1:0] s1_dist_reg;
    logic [DW-1:0] r1;
    logic [2:0]    c1;

    assign r1 = rdata[DW-1:0];
    assign c1 = rdata[DW+2:DW];

    // stage 2: compare and update
    logic          s2_valid_reg;
    logic          s2_ok_reg, s2_end_reg, s2_xw_reg;
    logic [DW-1:0] s2_dist_reg, s2_r_reg;
    logic [2:0]    s2_c_reg;
    logic [PW-1:0] s2_pdb_reg, s2_pbr_reg, s2_pdx_reg, s2_pxr_reg;

    // search state
    logic          have_reg;
    logic [DW-1:0] best_d_reg, best_r_reg;
    logic [2:0]    best_c_reg;
    logic [CW-1:0] cnt_reg [NR];
    logic [CW-1:0] cnt_upd [NR];

    logic s2_less, s2_win, s2_hit, s2_close;
    logic          fin_have;
    logic [DW-1:0] fin_d, fin_r;
    logic [2:0]    fin_c;

    // products against the held best and against the word now in stage 2,
    // since that word may become the best at this very edge
    logic [PW-1:0] pdb, pbr, pdx, pxr;

    assign pdb = PW'(s1_dist_reg) * PW'(best_r_reg);
    assign pbr = PW'(best_d_reg) * PW'(r1);
    assign pdx = PW'(s1_dist_reg) * PW'(s2_r_reg);
    assign pxr = PW'(s2_dist_reg) * PW'(r1);

    assign s2_less  = s2_xw_reg ? (s2_pdx_reg < s2_pxr_reg) : (s2_pdb_reg < s2_pbr_reg);
    assign s2_win   = s2_valid_reg && s2_ok_reg && (!have_reg || s2_less);
    assign s2_hit   = s2_valid_reg && s2_ok_reg && (s2_r_reg > s2_dist_reg)
                      && (int'(s2_c_reg) < NUM_CLASSES);
    assign s2_close = s2_valid_reg && s2_end_reg;
    assign fin_have = have_reg || s2_win;
    assign fin_d    = s2_win ? s2_dist_reg : best_d_reg;
    assign fin_r    = s2_win ? s2_r_reg : best_r_reg;
    assign fin_c    = s2_win ? s2_c_reg : best_c_reg;

    always_comb begin
        for (int k = 0; k < NR; k++) begin
            cnt_upd[k] = cnt_reg[k];
            if (s2_hit && (s2_c_reg == 3'(k)) && (cnt_reg[k] != wbc_pkg::CNT_MAX)) begin
                cnt_upd[k] = cnt_reg[k] + 1'b1;
            end
        end
    end

    // stage 3: closed observation, limit product in flight
    logic          s3_valid_reg;
    logic          s3_have_reg;
    logic [DW-1:0] s3_d_reg, s3_r_reg;
    logic [2:0]    s3_c_reg;
    logic [NR-1:0][CW-1:0] s3_cnt_reg;

    // stage 4: call decision, push
    logic          s4_have_reg;
    logic [DW-1:0] s4_d_reg;
    logic [2:0]    s4_c_reg;
    logic [MW-1:0] s4_prod_reg;
    logic [NR-1:0][CW-1:0] s4_cnt_reg;
    logic          made;

    assign made   = s4_have_reg && (MW'({s4_d_reg, 16'h0000}) < s4_prod_reg);
    assign q_push = s4_valid_reg && q_ready;

    always_comb begin
        q_data            = '0;
        q_data.made       = made;
        q_data.call_class = made ? s4_c_reg : 3'd0;
        q_data.have_best  = s4_have_reg;
        q_data.best_class = s4_c_reg;
        q_data.run_len    = run_len;
        q_data.counts     = s4_cnt_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_xw_reg    <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
            best_d_reg   <= '0;
            best_r_reg   <= DW'(1);
            best_c_reg   <= '0;
            for (int k = 0; k < NR; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (adv) begin
            s1_valid_reg <= acc && is_dist;
            s2_valid_reg <= s1_valid_reg;
            s2_xw_reg    <= s2_win && !s2_end_reg;
            s3_valid_reg <= s2_close;
            s4_valid_reg <= s3_valid_reg;
            if (s2_close) begin
                have_reg   <= 1'b0;
                best_d_reg <= '0;
                best_r_reg <= DW'(1);
                best_c_reg <= '0;
                for (int k = 0; k < NR; k++) begin
                    cnt_reg[k] <= '0;
                end
            end else begin
                if (s2_win) begin
                    have_reg   <= 1'b1;
                    best_d_reg <= s2_dist_reg;
                    best_r_reg <= s2_r_reg;
                    best_c_reg <= s2_c_reg;
                end
                for (int k = 0; k < NR; k++) begin
                    cnt_reg[k] <= cnt_upd[k];
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_ok_reg   <= idx_ok0;
            s1_end_reg  <= s_data.end_of_observation;
            s1_dist_reg <= s_data.distance[DW-1:0];

            s2_ok_reg   <= s1_ok_reg;
            s2_end_reg  <= s1_end_reg;
            s2_dist_reg <= s1_dist_reg;
            s2_r_reg    <= r1;
            s2_c_reg    <= c1;
            s2_pdb_reg  <= pdb;
            s2_pbr_reg  <= pbr;
            s2_pdx_reg  <= pdx;
            s2_pxr_reg  <= pxr;

            s3_have_reg <= fin_have;
            s3_d_reg    <= fin_d;
            s3_r_reg    <= fin_r;
            s3_c_reg    <= fin_c;
            for (int k = 0; k < NR; k++) begin
                s3_cnt_reg[k] <= cnt_upd[k];
            end

            s4_have_reg <= s3_have_reg;
            s4_d_reg    <= s3_d_reg;
            s4_c_reg    <= s3_c_reg;
            s4_cnt_reg  <= s3_cnt_reg;
            s4_prod_reg <= MW'(max_ratio) * MW'(s3_r_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wbc_back.sv =====
// wbc_back: turns each queued run into its call word and count words, one per
// cycle while m_ready is high, through a registered output. Depends on wbc_pkg.
`default_nettype none

module wbc_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire wbc_pkg::run_t q_data,
    output logic               q_pop,
    output logic               m_valid,
    output wbc_pkg::out_word_t m_data,
    input  wire logic          m_ready
);

    logic [wbc_pkg::RUN_LEN_W-1:0] step_reg, step_next;
    logic                          m_valid_reg, m_valid_next;
    wbc_pkg::out_word_t            m_data_reg, word;
    logic                          load, done;
    logic [2:0]                    k;

    assign load    = q_valid && (!m_valid_reg || m_ready);
    assign done    = (step_reg == q_data.run_len);
    assign q_pop   = load && done;
    assign k       = 3'(step_reg - 1'b1);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        word             = '0;
        word.call_made   = q_data.made;
        word.call_class  = q_data.call_class;
        word.last_of_run = done;
        if (step_reg != '0) begin
            word.is_count      = 1'b1;
            word.count_class   = k;
            word.overlap_count = (q_data.have_best && (q_data.best_class == k))
                                 ? '0 : q_data.counts[k];
        end
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
            step_next    = done ? '0 : step_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= word;
        end
    end

endmodule

`default_nettype wire
